// ===== src/format_string_printer_defines.svh =====
// ----------------------------------------------------------------------------
// format_string_printer_defines
// assertion macros of the format string printer
// ----------------------------------------------------------------------------
`ifndef FORMAT_STRING_PRINTER_DEFINES_SVH
`define FORMAT_STRING_PRINTER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define FSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FSP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// types, character codes and helpers of the format string printer
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int ARG_WIDTH_DEF = 32;
    localparam int ARG_FIELD_W   = 32;
    localparam int COUNT_W       = 31;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_C       = 8'h63;
    localparam logic [7:0] CHAR_D       = 8'h64;
    localparam logic [7:0] CHAR_I       = 8'h69;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic [3:0] BCD_ADJ_MIN  = 4'd5;
    localparam logic [3:0] BCD_ADJ      = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_CHAR,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT,
        S_END
    } t_state;

    // decimal digits needed for any value below 2**bits
    function automatic int f_dec_digits(input int bits);
        longint unsigned lim;
        longint unsigned p;
        int              n;
        lim = longint'(1) << bits;
        p   = 10;
        n   = 1;
        while (p < lim) begin
            p = p * 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ===== src/fsp_in_if.sv =====
// ----------------------------------------------------------------------------
// fsp_in_if
// format byte channel with its argument word
// ----------------------------------------------------------------------------
interface fsp_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         format_byte;
    logic               format_last;
    logic signed [31:0] argument;

    modport source (output valid, output format_byte, output format_last,
                    output argument, input ready);
    modport sink   (input valid, input format_byte, input format_last,
                    input argument, output ready);
endinterface

// ===== src/fsp_out_if.sv =====
// ----------------------------------------------------------------------------
// fsp_out_if
// result channel of the format string printer
// ----------------------------------------------------------------------------
interface fsp_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_char;
    logic               char_valid;
    logic               arg_consumed;
    logic               run_last;
    logic               format_done;
    logic signed [31:0] total_count;

    modport source (output valid, output out_char, output char_valid,
                    output arg_consumed, output run_last, output format_done,
                    output total_count, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input arg_consumed, input run_last, input format_done,
                    input total_count, output ready);
endinterface

// ===== src/format_string_printer.sv =====
// ----------------------------------------------------------------------------
// format_string_printer
// printf style conversion of a format string that arrives one byte per item
//
//   channel  dir  payload
//   i_fmt    in   format_byte, format_last, argument
//   o_res    out  out_char, char_valid, arg_consumed, run_last, format_done,
//                 total_count
//
// S_IDLE accepts each item; S_CHAR emits a literal, %c or %%, and S_PRE the
//   percent of an unknown conversion; %d/%i: S_CONV shifts the argument in,
//   one bit per step, S_SKIP drops leading zero digits, S_SIGN and S_DIGIT
//   emit sign and digits; S_END emits the end marker; a new item is taken
//   once the last result sits in the output register
// reset is synchronous and returns to the start of a format string
// a stalled output holds the sequencer in its emitting state
// ----------------------------------------------------------------------------
`include "format_string_printer_defines.svh"

module format_string_printer #(
    parameter int ARG_WIDTH = fsp_pkg::ARG_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fsp_in_if.sink           i_fmt,
    fsp_out_if.source        o_res
);

    localparam int AW = (ARG_WIDTH > fsp_pkg::ARG_FIELD_W) ? fsp_pkg::ARG_FIELD_W : ARG_WIDTH;
    localparam int ND = fsp_pkg::f_dec_digits(AW);
    localparam int BW = 4 * ND;
    localparam int CW = $clog2(AW);
    localparam int DW = $clog2(ND + 1);
    localparam int KW = fsp_pkg::COUNT_W;

    fsp_pkg::t_state r_state, n_state;
    logic            r_pending, n_pending;
    logic            r_first, n_first;
    logic [KW-1:0]   r_count, n_count;
    logic [7:0]      r_char, n_char;
    logic            r_last, n_last;
    logic            r_lone, n_lone;
    logic            r_cons, n_cons;
    logic            r_neg, n_neg;
    logic [AW-1:0]   r_mag, n_mag;
    logic [BW-1:0]   r_bcd, n_bcd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]   r_dig, n_dig;

    logic               r_o_valid, n_o_valid;
    logic [7:0]         r_o_char, n_o_char;
    logic               r_o_cv, n_o_cv;
    logic               r_o_cons, n_o_cons;
    logic               r_o_rl, n_o_rl;
    logic               r_o_done, n_o_done;
    logic signed [31:0] r_o_total, n_o_total;

    logic          l_free;
    logic [KW-1:0] l_inc;
    logic [AW-1:0] l_arg;
    logic          l_neg;
    logic [AW-1:0] l_mag;
    logic [3:0]    l_top;
    logic [3:0]    l_d;
    logic [BW-1:0] l_adj;
    logic          l_emit;
    logic [7:0]    l_echar;
    logic          l_econs;
    logic          l_erl;

    assign i_fmt.ready = (r_state == fsp_pkg::S_IDLE);

    assign o_res.valid        = r_o_valid;
    assign o_res.out_char     = r_o_char;
    assign o_res.char_valid   = r_o_cv;
    assign o_res.arg_consumed = r_o_cons;
    assign o_res.run_last     = r_o_rl;
    assign o_res.format_done  = r_o_done;
    assign o_res.total_count  = r_o_total;

    assign l_free = !r_o_valid || o_res.ready;
    assign l_inc  = (r_count == {KW{1'b1}}) ? r_count : r_count + KW'(1);
    assign l_arg  = i_fmt.argument[AW-1:0];
    assign l_neg  = l_arg[AW-1];
    assign l_mag  = l_neg ? (~l_arg + AW'(1)) : l_arg;
    assign l_top  = r_bcd[BW-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fsp_pkg::S_IDLE;
            r_pending <= 1'b0;
            r_first   <= 1'b1;
            r_count   <= '0;
            r_last    <= 1'b0;
            r_lone    <= 1'b0;
            r_cons    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_first   <= n_first;
            r_count   <= n_count;
            r_last    <= n_last;
            r_lone    <= n_lone;
            r_cons    <= n_cons;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_dig     <= n_dig;
        r_o_char  <= n_o_char;
        r_o_cv    <= n_o_cv;
        r_o_cons  <= n_o_cons;
        r_o_rl    <= n_o_rl;
        r_o_done  <= n_o_done;
        r_o_total <= n_o_total;
    end

    // double dabble adjust, one per bcd digit
    always_comb begin
        l_adj = '0;
        l_d   = '0;
        for (int k = 0; k < ND; k++) begin
            l_d = r_bcd[4*k +: 4];
            l_adj[4*k +: 4] = (l_d >= fsp_pkg::BCD_ADJ_MIN) ? l_d + fsp_pkg::BCD_ADJ : l_d;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_first   = r_first;
        n_count   = r_count;
        n_char    = r_char;
        n_last    = r_last;
        n_lone    = r_lone;
        n_cons    = r_cons;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_char  = r_o_char;
        n_o_cv    = r_o_cv;
        n_o_cons  = r_o_cons;
        n_o_rl    = r_o_rl;
        n_o_done  = r_o_done;
        n_o_total = r_o_total;
        l_emit    = 1'b0;
        l_echar   = r_char;
        l_econs   = 1'b0;
        l_erl     = 1'b0;

        unique case (r_state)
            fsp_pkg::S_IDLE: begin
                if (i_fmt.valid) begin
                    n_last  = i_fmt.format_last;
                    n_first = 1'b0;
                    n_cons  = 1'b0;
                    n_char  = i_fmt.format_byte;
                    if (i_fmt.format_last && r_first && !r_pending &&
                        i_fmt.format_byte == fsp_pkg::CHAR_PERCENT) begin
                        n_lone  = 1'b1;
                        n_state = fsp_pkg::S_END;
                    end else if (r_pending) begin
                        n_pending = 1'b0;
                        unique case (i_fmt.format_byte) inside
                            fsp_pkg::CHAR_C: begin
                                n_char  = i_fmt.argument[7:0];
                                n_cons  = 1'b1;
                                n_state = fsp_pkg::S_CHAR;
                            end
                            fsp_pkg::CHAR_PERCENT: begin
                                n_state = fsp_pkg::S_CHAR;
                            end
                            fsp_pkg::CHAR_D, fsp_pkg::CHAR_I: begin
                                n_mag   = l_mag;
                                n_neg   = l_neg;
                                n_bcd   = '0;
                                n_cnt   = CW'(AW - 1);
                                n_dig   = DW'(ND);
                                n_cons  = 1'b1;
                                n_state = fsp_pkg::S_CONV;
                            end
                            default: begin
                                n_state = fsp_pkg::S_PRE;
                            end
                        endcase
                    end else if (i_fmt.format_byte == fsp_pkg::CHAR_PERCENT &&
                                 !i_fmt.format_last) begin
                        n_pending = 1'b1;
                    end else begin
                        n_state = fsp_pkg::S_CHAR;
                    end
                end
            end
            fsp_pkg::S_PRE: begin
                if (l_free) begin
                    l_emit  = 1'b1;
                    l_echar = fsp_pkg::CHAR_PERCENT;
                    n_state = fsp_pkg::S_CHAR;
                end
            end
            fsp_pkg::S_CHAR: begin
                if (l_free) begin
                    l_emit  = 1'b1;
                    l_echar = r_char;
                    l_econs = r_cons;
                    l_erl   = !r_last;
                    n_state = r_last ? fsp_pkg::S_END : fsp_pkg::S_IDLE;
                end
            end
            fsp_pkg::S_CONV: begin
                n_bcd = {l_adj[BW-2:0], r_mag[AW-1]};
                n_mag = {r_mag[AW-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = fsp_pkg::S_SKIP;
                end
            end
            fsp_pkg::S_SKIP: begin
                if (l_top == 4'd0 && r_dig != DW'(1)) begin
                    n_bcd = {r_bcd[BW-5:0], 4'd0};
                    n_dig = r_dig - DW'(1);
                end else begin
                    n_state = r_neg ? fsp_pkg::S_SIGN : fsp_pkg::S_DIGIT;
                end
            end
            fsp_pkg::S_SIGN: begin
                if (l_free) begin
                    l_emit  = 1'b1;
                    l_echar = fsp_pkg::CHAR_MINUS;
                    l_econs = r_cons;
                    n_state = fsp_pkg::S_DIGIT;
                end
            end
            fsp_pkg::S_DIGIT: begin
                if (l_free) begin
                    l_emit  = 1'b1;
                    l_echar = fsp_pkg::CHAR_ZERO + {4'd0, l_top};
                    l_econs = r_cons;
                    l_erl   = (r_dig == DW'(1)) && !r_last;
                    n_bcd   = {r_bcd[BW-5:0], 4'd0};
                    n_dig   = r_dig - DW'(1);
                    if (r_dig == DW'(1)) begin
                        n_state = r_last ? fsp_pkg::S_END : fsp_pkg::S_IDLE;
                    end
                end
            end
            fsp_pkg::S_END: begin
                if (l_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = fsp_pkg::CHAR_NUL;
                    n_o_cv    = 1'b0;
                    n_o_cons  = 1'b0;
                    n_o_rl    = 1'b1;
                    n_o_done  = 1'b1;
                    n_o_total = r_lone ? '1 : signed'({1'b0, r_count});
                    n_count   = '0;
                    n_first   = 1'b1;
                    n_pending = 1'b0;
                    n_lone    = 1'b0;
                    n_last    = 1'b0;
                    n_state   = fsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsp_pkg::S_IDLE;
            end
        endcase

        if (l_emit) begin
            n_o_valid = 1'b1;
            n_o_char  = l_echar;
            n_o_cv    = 1'b1;
            n_o_cons  = l_econs;
            n_o_rl    = l_erl;
            n_o_done  = 1'b0;
            n_o_total = signed'({1'b0, l_inc});
            n_count   = l_inc;
            n_cons    = 1'b0;
        end
    end

    `FSP_ASSERT_ALWAYS(a_done_is_run_last, i_clk, i_rst_n,
        !(r_o_valid && r_o_done) || r_o_rl, "end marker without run_last")
    `FSP_ASSERT_ALWAYS(a_done_no_char, i_clk, i_rst_n,
        !(r_o_valid && r_o_done && r_o_cv), "end marker flagged as character")
    `FSP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n,
        r_state == fsp_pkg::S_END && l_free, r_count == '0 && r_first && !r_pending,
        "format state not cleared after end marker")
    `FSP_ASSERT_ALWAYS(a_digit_left, i_clk, i_rst_n,
        !(r_state == fsp_pkg::S_DIGIT || r_state == fsp_pkg::S_SKIP) || r_dig != '0,
        "digit counter ran out")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks format_string_printer against a predictor of its own: format
// strings are fed as bursts of items, every result is compared field by
// field with the expected character stream, and the output side stalls
// on a changing pattern
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]         out_char;
        logic               char_valid;
        logic               arg_consumed;
        logic               run_last;
        logic               format_done;
        logic signed [31:0] total_count;
    } t_printer_result;

    class printer_scoreboard;
        t_printer_result expected[$];
        bit              pct_open;
        bit [30:0]       char_count;
        bit              fresh_format = 1'b1;
        int              faults;

        function void restart();
            pct_open     = 1'b0;
            char_count   = '0;
            fresh_format = 1'b1;
        endfunction

        function void push_char(logic [7:0] ch, logic consumed);
            if (char_count != '1) begin
                char_count++;
            end
            expected.push_back('{out_char: ch, char_valid: 1'b1, arg_consumed: consumed,
                                 run_last: 1'b0, format_done: 1'b0,
                                 total_count: {1'b0, char_count}});
        endfunction

        function void push_end(logic signed [31:0] total);
            expected.push_back('{out_char: fsp_pkg::CHAR_NUL, char_valid: 1'b0,
                                 arg_consumed: 1'b0, run_last: 1'b0, format_done: 1'b1,
                                 total_count: total});
        endfunction

        function void push_decimal(logic [31:0] word);
            logic [31:0] magnitude;
            logic [3:0]  digit_q[$];
            logic        lead;
            magnitude = word[31] ? ~word + 32'd1 : word;
            do begin
                digit_q.push_front(4'(magnitude % 32'd10));
                magnitude = magnitude / 32'd10;
            end while (magnitude != 0);
            lead = 1'b1;
            if (word[31]) begin
                push_char(fsp_pkg::CHAR_MINUS, 1'b1);
                lead = 1'b0;
            end
            foreach (digit_q[k]) begin
                push_char(fsp_pkg::CHAR_ZERO + 8'(digit_q[k]), lead);
                lead = 1'b0;
            end
        endfunction

        function void note_item(logic [7:0] b, logic last, logic signed [31:0] arg);
            int first_new;
            first_new = expected.size();
            if (last && fresh_format && !pct_open && b == fsp_pkg::CHAR_PERCENT) begin
                push_end(-32'sd1);
            end else begin
                if (pct_open) begin
                    pct_open = 1'b0;
                    if (b == fsp_pkg::CHAR_C) begin
                        push_char(arg[7:0], 1'b1);
                    end else if (b == fsp_pkg::CHAR_PERCENT) begin
                        push_char(fsp_pkg::CHAR_PERCENT, 1'b0);
                    end else if (b == fsp_pkg::CHAR_D || b == fsp_pkg::CHAR_I) begin
                        push_decimal(arg);
                    end else begin
                        push_char(fsp_pkg::CHAR_PERCENT, 1'b0);
                        push_char(b, 1'b0);
                    end
                end else if (b == fsp_pkg::CHAR_PERCENT && !last) begin
                    pct_open = 1'b1;
                end else begin
                    push_char(b, 1'b0);
                end
                fresh_format = 1'b0;
                if (last) begin
                    push_end({1'b0, char_count});
                end
            end
            if (last) begin
                restart();
            end
            if (expected.size() > first_new) begin
                expected[$].run_last = 1'b1;
            end
        endfunction

        function void check_result(t_printer_result got);
            t_printer_result want;
            if (expected.size() == 0) begin
                if (faults < 10) begin
                    $display("%0t unexpected result char=%h total=%0d", $realtime,
                             got.out_char, got.total_count);
                end
                faults++;
                return;
            end
            want = expected.pop_front();
            if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                got.arg_consumed !== want.arg_consumed || got.run_last !== want.run_last ||
                got.format_done !== want.format_done ||
                got.total_count !== want.total_count) begin
                if (faults < 10) begin
                    $display("%0t mismatch exp char=%h cv=%b ac=%b rl=%b fd=%b total=%0d",
                             $realtime, want.out_char, want.char_valid, want.arg_consumed,
                             want.run_last, want.format_done, want.total_count);
                    $display("%0t          got char=%h cv=%b ac=%b rl=%b fd=%b total=%0d",
                             $realtime, got.out_char, got.char_valid, got.arg_consumed,
                             got.run_last, got.format_done, got.total_count);
                end
                faults++;
            end
        endfunction

        function int backlog();
            return expected.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsp_in_if  fmt_if ();
    fsp_out_if res_if ();

    format_string_printer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (fmt_if),
        .o_res   (res_if)
    );

    printer_scoreboard sb = new;
    t_printer_result   seen;
    int                items_sent;
    int                burst_left;
    bit                valid_held;
    int                stall_mode;
    int                mode_left;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(2);
            mode_left  <= $urandom_range(200, 40);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                res_if.ready <= 1'b1;
            end
            1: begin
                res_if.ready <= 1'($urandom_range(1));
            end
            default: begin
                res_if.ready <= ($urandom_range(7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen.out_char     = res_if.out_char;
                seen.char_valid   = res_if.char_valid;
                seen.arg_consumed = res_if.arg_consumed;
                seen.run_last     = res_if.run_last;
                seen.format_done  = res_if.format_done;
                seen.total_count  = res_if.total_count;
                sb.check_result(seen);
            end
            if (fmt_if.valid && fmt_if.ready) begin
                sb.note_item(fmt_if.format_byte, fmt_if.format_last, fmt_if.argument);
            end
        end
    end

    task automatic drive_item(logic [7:0] b, logic last, logic signed [31:0] arg);
        fmt_if.valid       <= 1'b1;
        fmt_if.format_byte <= b;
        fmt_if.format_last <= last;
        fmt_if.argument    <= arg;
        valid_held = 1'b1;
        do @(posedge i_clk); while (!fmt_if.ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            fmt_if.valid <= 1'b0;
            valid_held = 1'b0;
            repeat (($urandom_range(3) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1))
                @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(8);
        end
    endtask

    task automatic drain_results();
        if (valid_held) begin
            fmt_if.valid <= 1'b0;
            valid_held = 1'b0;
        end
        do @(negedge i_clk); while (sb.backlog() != 0);
        @(posedge i_clk);
    endtask

    task automatic put_format(string text, logic signed [31:0] arg);
        for (int k = 0; k < text.len(); k++) begin
            drive_item(text[k], k == text.len() - 1, arg);
        end
    endtask

    function automatic logic signed [31:0] pick_argument();
        case ($urandom_range(7))
            0: return {1'b1, 31'd0};
            1: return {1'b0, {31{1'b1}}};
            2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
            3, 4: return $signed($urandom_range(2000)) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_conversion();
        case ($urandom_range(9))
            0, 1: return fsp_pkg::CHAR_C;
            2, 3, 4: return fsp_pkg::CHAR_D;
            5, 6: return fsp_pkg::CHAR_I;
            7: return fsp_pkg::CHAR_PERCENT;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_format();
        int   tokens;
        int   pick;
        logic closing;
        tokens = $urandom_range(8, 1);
        if ($urandom_range(19) == 0) begin
            drive_item(fsp_pkg::CHAR_PERCENT, 1'b1, pick_argument());
            return;
        end
        for (int t = 0; t < tokens; t++) begin
            closing = (t == tokens - 1);
            pick = $urandom_range(9);
            if (pick < 4) begin
                drive_item(8'($urandom_range(255)), closing, pick_argument());
            end else if (pick < 9) begin
                drive_item(fsp_pkg::CHAR_PERCENT, 1'b0, pick_argument());
                drive_item(pick_conversion(), closing, pick_argument());
            end else if (closing) begin
                drive_item(fsp_pkg::CHAR_PERCENT, 1'b1, pick_argument());
            end else begin
                drive_item(fsp_pkg::CHAR_NUL, 1'b0, pick_argument());
            end
        end
    endtask

    initial begin
        int random_start;
        fmt_if.valid       = 1'b0;
        fmt_if.format_byte = '0;
        fmt_if.format_last = 1'b0;
        fmt_if.argument    = '0;
        res_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone percent, literals with nul and top byte, %c, %%, %d/%i, %q, x%
        put_format("%", 32'sd0);
        drive_item("A", 1'b0, 32'sd5);
        drive_item(fsp_pkg::CHAR_NUL, 1'b0, 32'sd5);
        drive_item(8'hFF, 1'b1, 32'sd5);
        put_format("%c", 32'sd0);
        put_format("%c%%", -32'sd1);
        put_format("%d", {1'b1, 31'd0});
        put_format("%i%d", {1'b0, {31{1'b1}}});
        put_format("%d", 32'sd0);
        put_format("%i", -32'sd1);
        put_format("%q", 32'sd7);
        put_format("x%", 32'sd9);

        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < 370) begin
            send_random_format();
            if ($urandom_range(15) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (80) @(posedge i_clk);
        if (sb.backlog() != 0) begin
            $display("%0d expected results never arrived", sb.backlog());
        end
        if (sb.faults == 0 && sb.backlog() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
